// File: rtl/core/gha_pkg.sv
package gha_pkg;

   // Field widths fixed by the item formats
   localparam int SLOT_W   = 8;
   localparam int GEN_W    = 32;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 3;

   localparam int SLOT_COUNT_DEFAULT = 256;

   // Generation at which a freed slot is retired instead of recycled
   localparam logic [GEN_W-1:0] GEN_LIMIT = 32'hFFFF_FFFE;
   localparam logic [GEN_W-1:0] GEN_FIRST = 32'h0000_0001;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_STALE   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_RETIRED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd4;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [SLOT_W-1:0] slot_index;
      logic [GEN_W-1:0]  gen_tag;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot_out;
      logic [GEN_W-1:0]    gen_out;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

// File: rtl/core/gha_ram.sv
// Simple dual-port RAM: one write port, one registered read port
module gha_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/generational_handle_allocator.sv
// Generational handle allocator. Every request (allocate, free, check) runs in
// two steps: the accept edge reads the slot entry memory and the top of the free
// stack, then the execute step does the update and loads the response register.
// No new request enters until the execute step of the previous one is done.
// A request is accepted while the previous response still waits, and the execute
// step then holds until the response register empties.
// Each slot entry holds its generation plus an in-use flag; both are written when
// the slot is first issued, so no clearing pass runs after reset. The free stack
// stores the slot together with its generation, so a pop needs no second read.
module generational_handle_allocator #(
   parameter int SLOT_COUNT = gha_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gha_pkg::rsp_type rsp_data
);

   import gha_pkg::*;

   localparam int IDX_W   = $clog2(SLOT_COUNT);
   localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
   localparam int CMP_W   = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam int ENTRY_W = GEN_W + 1;
   localparam int STACK_W = GEN_W + IDX_W;
   localparam logic [CNT_W-1:0] SLOT_MAX = CNT_W'(SLOT_COUNT);

   state_type        state_ff, state_in;
   req_type          req_ff;
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [CNT_W-1:0] issued_count_ff, issued_count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic               accept;
   logic               fire;
   logic [CMP_W-1:0]   slot_cmp;
   logic [IDX_W-1:0]   top_idx;

   logic               ent_we;
   logic [IDX_W-1:0]   ent_waddr;
   logic [ENTRY_W-1:0] ent_wdata;
   logic [ENTRY_W-1:0] ent_rdata;
   logic               stk_we;
   logic [STACK_W-1:0] stk_wdata;
   logic [STACK_W-1:0] stk_rdata;

   logic               cur_in_use;
   logic [GEN_W-1:0]   cur_gen;
   logic [GEN_W-1:0]   next_gen;
   logic [IDX_W-1:0]   pop_slot;
   logic [GEN_W-1:0]   pop_gen;
   logic               out_of_range;

   // Request side decode
   assign accept   = req_valid && req_ready;
   assign top_idx  = IDX_W'(free_count_ff - CNT_W'(1));

   // Slot entries: {in_use, generation}
   gha_ram #(
      .DEPTH (SLOT_COUNT),
      .WIDTH (ENTRY_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_en   (accept),
      .rd_addr (IDX_W'(CMP_W'(req_data.slot_index))),
      .rd_data (ent_rdata)
   );

   // Free stack: {generation, slot}
   gha_ram #(
      .DEPTH (SLOT_COUNT),
      .WIDTH (STACK_W)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (IDX_W'(free_count_ff)),
      .wr_data (stk_wdata),
      .rd_en   (accept),
      .rd_addr (top_idx),
      .rd_data (stk_rdata)
   );

   // Capture request
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         free_count_ff   <= '0;
         issued_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         free_count_ff   <= free_count_in;
         issued_count_ff <= issued_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // Fields read back from the memories
   assign cur_in_use   = ent_rdata[GEN_W];
   assign cur_gen      = ent_rdata[GEN_W-1:0];
   assign next_gen     = cur_gen + GEN_W'(1);
   assign pop_slot     = stk_rdata[IDX_W-1:0];
   assign pop_gen      = stk_rdata[STACK_W-1:IDX_W];
   assign slot_cmp     = CMP_W'(req_ff.slot_index);
   assign out_of_range = (req_ff.func != FUNC_ALLOC && req_ff.func != FUNC_FREE &&
                          req_ff.func != FUNC_CHECK) ||
                         (slot_cmp >= CMP_W'(issued_count_ff));

   // Next state, memory updates and response
   always_comb begin
      state_in        = state_ff;
      free_count_in   = free_count_ff;
      issued_count_in = issued_count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_in          = '0;
      ent_we          = 1'b0;
      ent_waddr       = IDX_W'(slot_cmp);
      ent_wdata       = '0;
      stk_we          = 1'b0;
      stk_wdata       = '0;
      fire            = 1'b0;
      req_ready       = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               fire         = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               ent_waddr    = IDX_W'(slot_cmp);
               if (req_ff.func == FUNC_ALLOC) begin
                  if (free_count_ff != '0) begin
                     // Reuse the most recently freed slot
                     free_count_in   = free_count_ff - CNT_W'(1);
                     ent_we          = 1'b1;
                     ent_waddr       = pop_slot;
                     ent_wdata       = {1'b1, pop_gen};
                     rsp_in.slot_out = SLOT_W'(pop_slot);
                     rsp_in.gen_out  = pop_gen;
                     rsp_in.status   = STATUS_OK;
                  end else if (issued_count_ff < SLOT_MAX) begin
                     // Issue a fresh slot
                     issued_count_in = issued_count_ff + CNT_W'(1);
                     ent_we          = 1'b1;
                     ent_waddr       = IDX_W'(issued_count_ff);
                     ent_wdata       = {1'b1, GEN_FIRST};
                     rsp_in.slot_out = SLOT_W'(issued_count_ff);
                     rsp_in.gen_out  = GEN_FIRST;
                     rsp_in.status   = STATUS_OK;
                  end else begin
                     rsp_in.status = STATUS_FULL;
                  end
               end else if (out_of_range) begin
                  rsp_in.slot_out = req_ff.slot_index;
                  rsp_in.status   = STATUS_RANGE;
               end else if (req_ff.func == FUNC_FREE) begin
                  rsp_in.slot_out = req_ff.slot_index;
                  rsp_in.gen_out  = cur_gen;
                  if (!cur_in_use) begin
                     rsp_in.status = STATUS_STALE;
                  end else if (cur_gen < GEN_LIMIT) begin
                     // Bump the generation and push the slot
                     ent_we         = 1'b1;
                     ent_wdata      = {1'b0, next_gen};
                     rsp_in.gen_out = next_gen;
                     rsp_in.status  = STATUS_OK;
                     if (free_count_ff < SLOT_MAX) begin
                        stk_we        = 1'b1;
                        stk_wdata     = {next_gen, IDX_W'(slot_cmp)};
                        free_count_in = free_count_ff + CNT_W'(1);
                     end
                  end else begin
                     // Retire: release it but never recycle
                     ent_we        = 1'b1;
                     ent_wdata     = {1'b0, cur_gen};
                     rsp_in.status = STATUS_RETIRED;
                  end
               end else begin
                  // Check handle against the live entry
                  rsp_in.slot_out = req_ff.slot_index;
                  rsp_in.gen_out  = cur_gen;
                  rsp_in.status   = (cur_in_use && req_ff.gen_tag == cur_gen) ?
                                    STATUS_OK : STATUS_STALE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: test/tb.sv
module tb;
   import gha_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = SLOT_COUNT_DEFAULT;
   localparam int RESET_LEN   = 12;
   localparam int GAP_MAX     = 13;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 20;
   localparam int HOLD_LEN    = 400;
   localparam int HOLD_AT_A   = 3000;
   localparam int HOLD_AT_B   = 20000;
   localparam int REPORT_MAX  = 10;

   // func value 3 has no meaning; the block answers it as out of range
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef enum int {
      MIX_BALANCED,
      MIX_FILL,
      MIX_DRAIN
   } mix_kind;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   generational_handle_allocator #(
      .SLOT_COUNT(SLOTS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow of the allocator state
   logic [GEN_W-1:0]  shadow_gen [SLOTS];
   logic              shadow_live [SLOTS];
   logic [SLOT_W-1:0] shadow_stack [SLOTS];
   int                shadow_free;
   int                shadow_issued;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];

   int items_accepted  = 0;
   int rsps_checked    = 0;
   int mismatch_cnt    = 0;
   int status_seen [8];
   logic long_hold = 1'b0;

   initial begin
      shadow_free   = 0;
      shadow_issued = 0;
      for (int i = 0; i < SLOTS; i++) begin
         shadow_live[i] = 1'b0;
         shadow_gen[i]  = '0;
         shadow_stack[i] = '0;
      end
      for (int i = 0; i < 8; i++)
         status_seen[i] = 0;
   end

   // Expected response for one request; updates the shadow state
   function automatic rsp_type predict_handle(input req_type r);
      rsp_type           res;
      logic [SLOT_W-1:0] s;
      logic [GEN_W-1:0]  g;
      res.slot_out = r.slot_index;
      res.gen_out  = '0;
      res.status   = STATUS_RANGE;
      if (r.func == FUNC_ALLOC) begin
         if (shadow_free > 0) begin
            shadow_free--;
            s = shadow_stack[shadow_free];
         end else if (shadow_issued < SLOTS) begin
            s = shadow_issued[SLOT_W-1:0];
            shadow_gen[s] = GEN_FIRST;
            shadow_issued++;
         end else begin
            res.slot_out = '0;
            res.status   = STATUS_FULL;
            return res;
         end
         shadow_live[s] = 1'b1;
         res.slot_out = s;
         res.gen_out  = shadow_gen[s];
         res.status   = STATUS_OK;
         return res;
      end
      if (r.func == FUNC_UNUSED || int'(r.slot_index) >= shadow_issued)
         return res;
      s = r.slot_index;
      g = shadow_gen[s];
      res.gen_out = g;
      if (r.func == FUNC_FREE) begin
         if (!shadow_live[s]) begin
            res.status = STATUS_STALE;
            return res;
         end
         shadow_live[s] = 1'b0;
         if (g < GEN_LIMIT) begin
            g = g + 1'b1;
            shadow_gen[s] = g;
            if (shadow_free < SLOTS) begin
               shadow_stack[shadow_free] = s;
               shadow_free++;
            end
            res.gen_out = g;
            res.status  = STATUS_OK;
         end else begin
            res.status = STATUS_RETIRED;
         end
         return res;
      end
      // check
      res.status = (shadow_live[s] && r.gen_tag == g) ? STATUS_OK : STATUS_STALE;
      return res;
   endfunction

   function automatic req_type make_req(input logic [FUNC_W-1:0] f,
                                        input logic [SLOT_W-1:0] s,
                                        input logic [GEN_W-1:0] t);
      req_type r;
      r.func       = f;
      r.slot_index = s;
      r.gen_tag    = t;
      return r;
   endfunction

   // Random live slot from the shadow; the shadow may lag a couple of items
   function automatic bit pick_live(output logic [SLOT_W-1:0] s);
      int start;
      int idx;
      s = '0;
      if (shadow_issued == 0)
         return 1'b0;
      start = $urandom_range(0, shadow_issued - 1);
      for (int k = 0; k < shadow_issued; k++) begin
         idx = (start + k) % shadow_issued;
         if (shadow_live[idx]) begin
            s = idx[SLOT_W-1:0];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic req_type random_req(input mix_kind mix);
      int                roll;
      int                w_alloc;
      int                w_free;
      int                w_check;
      logic [SLOT_W-1:0] s;
      logic [GEN_W-1:0]  t;
      req_type           r;
      case (mix)
         MIX_FILL: begin
            w_alloc = 75; w_free = 10; w_check = 12;
         end
         MIX_DRAIN: begin
            w_alloc = 12; w_free = 55; w_check = 30;
         end
         default: begin
            w_alloc = 35; w_free = 30; w_check = 30;
         end
      endcase
      s = SLOT_W'($urandom_range(0, SLOTS - 1));
      t = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < w_alloc) begin
         r = make_req(FUNC_ALLOC, s, t);
      end else if (roll < w_alloc + w_free) begin
         // mostly live handles, some double frees and out-of-range slots
         if ($urandom_range(0, 99) < 85)
            void'(pick_live(s));
         r = make_req(FUNC_FREE, s, t);
      end else if (roll < w_alloc + w_free + w_check) begin
         if ($urandom_range(0, 99) < 85 && pick_live(s)) begin
            roll = $urandom_range(0, 99);
            if (roll < 65)
               t = shadow_gen[s];
            else if (roll < 80)
               t = shadow_gen[s] ^ (32'h1 << $urandom_range(0, GEN_W - 1));
         end
         r = make_req(FUNC_CHECK, s, t);
      end else begin
         r = make_req(FUNC_UNUSED, s, t);
      end
      return r;
   endfunction

   // Driver: one request item per handshake, random gaps between items
   int gap_left = 0;
   bit no_gap   = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(predict_handle(req_data));
            items_accepted++;
            if ($urandom_range(0, 39) == 0)
               no_gap = !no_gap;
            gap_left = no_gap ? 0 : $urandom_range(0, GAP_MAX);
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_data  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each response item with the oldest expectation
   int stall_left = 0;
   bit no_stall   = 1'b0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               if (mismatch_cnt < REPORT_MAX)
                  $display("ERROR: response with nothing expected: slot %0d gen %h st %0d",
                           rsp_data.slot_out, rsp_data.gen_out, rsp_data.status);
               mismatch_cnt++;
            end else begin
               want = expected_rsps.pop_front();
               status_seen[want.status]++;
               if (rsp_data.slot_out !== want.slot_out || rsp_data.gen_out !== want.gen_out
                   || rsp_data.status !== want.status) begin
                  if (mismatch_cnt < REPORT_MAX)
                     $display("ERROR: rsp %0d exp slot %0d gen %h st %0d, got slot %0d gen %h st %0d",
                              rsps_checked, want.slot_out, want.gen_out, want.status,
                              rsp_data.slot_out, rsp_data.gen_out, rsp_data.status);
                  mismatch_cnt++;
               end
            end
            rsps_checked++;
            if ($urandom_range(0, 39) == 0)
               no_stall = !no_stall;
            stall_left = no_stall ? 0 : $urandom_range(0, GAP_MAX);
         end
         if (long_hold) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Cycle count: long receiver hold-offs and the run timeout
   int cycle_cnt = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt == HOLD_AT_A || cycle_cnt == HOLD_AT_B)
         hold_left = HOLD_LEN;
      if (hold_left > 0)
         hold_left--;
      long_hold <= (hold_left > 0);
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Stimulus: directed items, then phases of random traffic
   task automatic queue_req(input req_type r);
      while (pending_reqs.size() >= 2)
         @(negedge clock);
      pending_reqs.push_back(r);
   endtask

   initial begin
      int phase_len [4];
      mix_kind phase_mix [4];
      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fresh slots, check hits and misses, range edges
      queue_req(make_req(FUNC_ALLOC, 8'd0, 32'd0));
      queue_req(make_req(FUNC_ALLOC, 8'hFF, 32'hFFFF_FFFF));
      queue_req(make_req(FUNC_CHECK, 8'd0, 32'd1));
      queue_req(make_req(FUNC_CHECK, 8'd0, 32'hFFFF_FFFF));
      queue_req(make_req(FUNC_CHECK, 8'd1, 32'd0));
      queue_req(make_req(FUNC_CHECK, 8'd2, 32'd1));
      queue_req(make_req(FUNC_CHECK, 8'hFF, 32'd1));
      // free, double free, check of a freed handle
      queue_req(make_req(FUNC_FREE, 8'd0, 32'd0));
      queue_req(make_req(FUNC_FREE, 8'd0, 32'd0));
      queue_req(make_req(FUNC_CHECK, 8'd0, 32'd2));
      queue_req(make_req(FUNC_FREE, 8'd1, 32'hFFFF_FFFF));
      // LIFO reuse, then a fresh slot once the stack is empty
      queue_req(make_req(FUNC_ALLOC, 8'd0, 32'd0));
      queue_req(make_req(FUNC_ALLOC, 8'd0, 32'd0));
      queue_req(make_req(FUNC_ALLOC, 8'hFF, 32'hFFFF_FFFF));
      // unknown func and out-of-range free
      queue_req(make_req(FUNC_UNUSED, 8'd0, 32'd0));
      queue_req(make_req(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF));
      queue_req(make_req(FUNC_FREE, 8'hFF, 32'd0));
      queue_req(make_req(FUNC_CHECK, 8'd0, 32'd2));
      queue_req(make_req(FUNC_FREE, 8'd2, 32'd0));
      // Retiring a slot takes about 2^32 frees of it, far beyond this run.

      // balanced, fill until full, drain, balanced again
      phase_mix[0] = MIX_BALANCED; phase_len[0] = 300;
      phase_mix[1] = MIX_FILL;     phase_len[1] = 450;
      phase_mix[2] = MIX_DRAIN;    phase_len[2] = 500;
      phase_mix[3] = MIX_BALANCED; phase_len[3] = 700;
      for (int p = 0; p < 4; p++)
         for (int n = 0; n < phase_len[p]; n++)
            queue_req(random_req(phase_mix[p]));

      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_rsps.size() != 0) begin
         $display("ERROR: %0d responses never arrived", expected_rsps.size());
         mismatch_cnt += expected_rsps.size();
      end

      $display("%0d requests, %0d responses checked, %0d mismatches",
               items_accepted, rsps_checked, mismatch_cnt);
      $display("status mix: ok %0d, range %0d, stale %0d, retired %0d, full %0d",
               status_seen[STATUS_OK], status_seen[STATUS_RANGE], status_seen[STATUS_STALE],
               status_seen[STATUS_RETIRED], status_seen[STATUS_FULL]);
      if (mismatch_cnt == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
